/* rtl/core/kvst_pkg.sv */
package kvst_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 64;

  // fixed field widths of the beats
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IDX_OUT_W = 6;
  localparam int unsigned CNT_OUT_W = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_REWIND = 3'd3,
    CMD_NEXT   = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_ITER_END  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  // one RAM word
  typedef struct packed {
    logic              occ;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } slot_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_scan;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/core/kvst_ram.sv */
module kvst_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/kvst_ctrl.sv */
module kvst_ctrl import kvst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dp_stat_t stat_i,
  output ctl_t     ctl_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.needs_scan ? S_SCAN : S_FINISH;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o        = '0;
    ctl_o.load   = (state_q == S_IDLE) && in_valid_i;
    ctl_o.scan   = (state_q == S_SCAN);
    ctl_o.commit = (state_q == S_FINISH) && stat_i.out_free;
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/kvst_dpath.sv */
module kvst_dpath import kvst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctl_t                 ctl_i,
  output dp_stat_t             stat_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [DATA_W-1:0]    key_i,
  input  logic [DATA_W-1:0]    value_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [IDX_OUT_W-1:0] slot_index_o,
  output logic [DATA_W-1:0]    found_key_o,
  output logic [DATA_W-1:0]    found_value_o,
  output logic [CNT_OUT_W-1:0] entry_count_o,
  output logic [CNT_OUT_W-1:0] high_water_o
);

  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SLOT_W  = $bits(slot_t);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  // command beat
  cmd_e              cmd_q;
  logic [DATA_W-1:0] key_q, value_q;

  // scan state
  logic [CNT_W-1:0]  ptr_q;
  logic [IDX_W-1:0]  chk_q;
  logic              rd_vld_q;
  logic              hit_q, free_q;
  logic [IDX_W-1:0]  hit_idx_q, free_idx_q;
  logic [DATA_W-1:0] cap_key_q, cap_val_q;

  // table bookkeeping
  logic [CNT_W-1:0]  count_q, used_q, iter_q;
  logic [CNT_W-1:0]  count_d, used_d, iter_d;

  // result register
  logic                 out_valid_q;
  status_e              o_status_q;
  logic [IDX_OUT_W-1:0] o_idx_q;
  logic [DATA_W-1:0]    o_key_q, o_val_q;
  logic [CNT_OUT_W-1:0] o_cnt_q, o_hw_q;

  // RAM port
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  slot_t             ram_wslot, rd_slot;
  logic [SLOT_W-1:0] ram_rdata;

  // scan compare
  logic below_mark, match, free_now, issue;

  // commit results
  status_e           res_status;
  logic [IDX_W-1:0]  res_idx;
  logic [DATA_W-1:0] res_key, res_val;
  cmd_e              in_cmd;

  assign in_cmd  = cmd_e'(command_i);
  assign rd_slot = slot_t'(ram_rdata);

  // slots at or above the mark were never written and count as free
  assign below_mark = (ptr_q < used_q);
  assign match      = rd_vld_q && rd_slot.occ &&
                      ((cmd_q == CMD_NEXT) || (rd_slot.key == key_q));
  assign free_now   = rd_vld_q && !rd_slot.occ && !free_q;
  assign issue      = ctl_i.scan && !match && below_mark;
  assign ram_re     = issue;

  always_comb begin
    stat_o            = '0;
    stat_o.needs_scan = (in_cmd == CMD_INSERT) || (in_cmd == CMD_REMOVE) ||
                        (in_cmd == CMD_LOOKUP) || (in_cmd == CMD_NEXT);
    stat_o.scan_done  = match || (!rd_vld_q && !below_mark);
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // outcome of the command, applied on commit
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = hit_idx_q;
    ram_wslot.occ   = 1'b1;
    ram_wslot.key   = key_q;
    ram_wslot.value = value_q;
    count_d         = count_q;
    used_d          = used_q;
    iter_d          = iter_q;
    res_status      = ST_OK;
    res_idx         = '0;
    res_key         = '0;
    res_val         = '0;
    unique case (cmd_q)
      CMD_INSERT: begin
        if (hit_q) begin
          ram_we  = 1'b1;
          res_idx = hit_idx_q;
        end else if (free_q) begin
          ram_we    = 1'b1;
          ram_waddr = free_idx_q;
          count_d   = count_q + CNT_W'(1);
          res_idx   = free_idx_q;
        end else if (used_q < DEPTH_C) begin
          ram_we    = 1'b1;
          ram_waddr = used_q[IDX_W-1:0];
          used_d    = used_q + CNT_W'(1);
          count_d   = count_q + CNT_W'(1);
          res_idx   = used_q[IDX_W-1:0];
        end else begin
          res_status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (hit_q) begin
          ram_we        = 1'b1;
          ram_wslot.occ = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - CNT_W'(1);
          end
          res_idx = hit_idx_q;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      CMD_LOOKUP: begin
        if (hit_q) begin
          res_idx = hit_idx_q;
          res_key = cap_key_q;
          res_val = cap_val_q;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      CMD_REWIND: begin
        iter_d = '0;
      end
      CMD_NEXT: begin
        if (hit_q) begin
          iter_d  = CNT_W'(hit_idx_q) + CNT_W'(1);
          res_idx = hit_idx_q;
          res_key = cap_key_q;
          res_val = cap_val_q;
        end else begin
          iter_d     = DEPTH_C;
          res_status = ST_ITER_END;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q       <= CMD_REWIND;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      count_q     <= '0;
      used_q      <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.load) begin
        cmd_q    <= in_cmd;
        ptr_q    <= (in_cmd == CMD_NEXT) ? iter_q : '0;
        rd_vld_q <= 1'b0;
        hit_q    <= 1'b0;
        free_q   <= 1'b0;
      end else begin
        rd_vld_q <= issue;
        if (issue) begin
          ptr_q <= ptr_q + CNT_W'(1);
        end
        if (ctl_i.scan && match) begin
          hit_q <= 1'b1;
        end
        if (ctl_i.scan && free_now) begin
          free_q <= 1'b1;
        end
      end
      if (ctl_i.commit) begin
        count_q <= count_d;
        used_q  <= used_d;
        iter_q  <= iter_d;
      end
      if (ctl_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (issue) begin
      chk_q <= ptr_q[IDX_W-1:0];
    end
    if (ctl_i.scan && match) begin
      hit_idx_q <= chk_q;
      cap_key_q <= rd_slot.key;
      cap_val_q <= rd_slot.value;
    end
    if (ctl_i.scan && free_now) begin
      free_idx_q <= chk_q;
    end
    if (ctl_i.commit) begin
      o_status_q <= res_status;
      o_idx_q    <= IDX_OUT_W'(res_idx);
      o_key_q    <= res_key;
      o_val_q    <= res_val;
      o_cnt_q    <= CNT_OUT_W'(count_d);
      o_hw_q     <= CNT_OUT_W'(used_d);
    end
  end

  kvst_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we && ctl_i.commit),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wslot),
    .re_i    (ram_re),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = o_status_q;
  assign slot_index_o  = o_idx_q;
  assign found_key_o   = o_key_q;
  assign found_value_o = o_val_q;
  assign entry_count_o = o_cnt_q;
  assign high_water_o  = o_hw_q;

endmodule

/* rtl/core/key_value_slot_table_unit.sv */
// Key/value slot table: TABLE_DEPTH slots of 32-bit key, 32-bit value and
// an occupied flag, kept in one single-port-read RAM word per slot.
// Input channel (in_valid_i / in_stall_o) takes one command beat:
// insert, remove, lookup, rewind iterator or iterator next. Output channel
// (out_valid_o / out_stall_i) returns exactly one result beat per command
// with status, slot index, found key/value, entry count and high-water mark.
// Insert, remove, lookup and next walk the slots below the high-water mark,
// one RAM read per cycle with the compare in the cycle after the read; a
// hit ends the walk early. Next starts its walk at the iterator, while
// rewind and unused codes skip the walk and go straight to the commit.
// One command is in flight at a time.
// The result sits in an output register: while it waits on a stalled
// receiver the next command is already accepted and worked, and only its
// final commit waits for the register to free up.
// Reset clears the occupied count, high-water mark and iterator. Slots at
// or above the high-water mark are treated as free, so the RAM needs no
// clearing pass and the block takes commands right after reset.
module key_value_slot_table_unit import kvst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command beat
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [DATA_W-1:0]    key_i,
  input  logic [DATA_W-1:0]    value_i,
  // result beat
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [IDX_OUT_W-1:0] slot_index_o,
  output logic [DATA_W-1:0]    found_key_o,
  output logic [DATA_W-1:0]    found_value_o,
  output logic [CNT_OUT_W-1:0] entry_count_o,
  output logic [CNT_OUT_W-1:0] high_water_o
);

  ctl_t     ctl;
  dp_stat_t stat;

  // sequencer: idle -> scan (only when the command needs one) -> finish (commit once the result register frees)
  kvst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  // slot RAM, scan compare, bookkeeping and result register
  kvst_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .command_i     (command_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .slot_index_o  (slot_index_o),
    .found_key_o   (found_key_o),
    .found_value_o (found_value_o),
    .entry_count_o (entry_count_o),
    .high_water_o  (high_water_o)
  );

endmodule

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kvst_pkg::*;

  localparam int DEPTH          = DEFAULT_TABLE_DEPTH;
  // worst case between two handshakes: a full scan plus long random stalls
  localparam int WATCHDOG_LIMIT = 4000;

  // command codes the block leaves unused; it must answer them and change nothing
  localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  localparam logic [DATA_W-1:0] WORD_MIN   = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_MAX   = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_ZERO  = 32'h0000_0000;
  localparam logic [DATA_W-1:0] WORD_ONES  = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_ALT_A = 32'h5555_5555;
  localparam logic [DATA_W-1:0] WORD_ALT_B = 32'hAAAA_AAAA;

  // one expected result beat
  typedef struct {
    status_e                status;
    logic [IDX_OUT_W-1:0]   idx;
    logic [DATA_W-1:0]      fkey;
    logic [DATA_W-1:0]      fval;
    logic [CNT_OUT_W-1:0]   count;
    logic [CNT_OUT_W-1:0]   mark;
  } table_answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     command_i   = '0;
  logic [DATA_W-1:0]    key_i       = '0;
  logic [DATA_W-1:0]    value_i     = '0;

  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [IDX_OUT_W-1:0] slot_index_o;
  logic [DATA_W-1:0]    found_key_o;
  logic [DATA_W-1:0]    found_value_o;
  logic [CNT_OUT_W-1:0] entry_count_o;
  logic [CNT_OUT_W-1:0] high_water_o;

  // idle rates in percent, changed between test phases
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int error_count = 0;

  // answers still owed by the block, oldest first
  table_answer_t pending_answers[$];

  // shadow copy of the table; key/value are only read where occupied
  logic [DATA_W-1:0] slot_key [DEPTH];
  logic [DATA_W-1:0] slot_val [DEPTH];
  bit                slot_used [DEPTH];
  int                tbl_count = 0;
  int                tbl_mark  = 0;
  int                iter_pos  = 0;

  // keys the random phases draw from, so hits are common
  logic [DATA_W-1:0] key_pool[$];

  always #5 clk_i = ~clk_i;

  key_value_slot_table_unit #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .command_i,
    .key_i,
    .value_i,
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .slot_index_o,
    .found_key_o,
    .found_value_o,
    .entry_count_o,
    .high_water_o
  );

  // ---------------------------------------------------------------------------
  // Shadow table
  // ---------------------------------------------------------------------------

  // linear search below the mark, -1 on a miss
  function automatic int find_slot(logic [DATA_W-1:0] key);
    for (int i = 0; i < tbl_mark; i++) begin
      if (slot_used[i] && slot_key[i] == key) return i;
    end
    return -1;
  endfunction

  // a key that no occupied slot holds right now
  function automatic logic [DATA_W-1:0] fresh_key();
    logic [DATA_W-1:0] k;
    do k = $urandom; while (find_slot(k) >= 0);
    return k;
  endfunction

  // applies one accepted command to the shadow table and returns its answer
  function automatic table_answer_t apply_command(logic [CMD_W-1:0] cmd,
                                                  logic [DATA_W-1:0] key,
                                                  logic [DATA_W-1:0] value);
    table_answer_t ans;
    int hit;
    int pos;
    bit got;
    ans.status = ST_OK;
    ans.idx    = '0;
    ans.fkey   = '0;
    ans.fval   = '0;
    case (cmd)
      CMD_INSERT: begin
        hit = find_slot(key);
        if (hit >= 0) begin
          // matching key: value overwrite only
          slot_val[hit] = value;
          ans.idx       = IDX_OUT_W'(hit);
        end else begin
          // lowest hole below the mark wins, else append at the mark
          pos = -1;
          for (int i = 0; i < tbl_mark; i++) begin
            if (!slot_used[i] && pos < 0) pos = i;
          end
          if (pos < 0 && tbl_mark < DEPTH) begin
            pos = tbl_mark;
            tbl_mark++;
          end
          if (pos >= 0) begin
            slot_key[pos]  = key;
            slot_val[pos]  = value;
            slot_used[pos] = 1'b1;
            tbl_count++;
            ans.idx = IDX_OUT_W'(pos);
          end else begin
            ans.status = ST_FULL;
          end
        end
      end
      CMD_REMOVE: begin
        hit = find_slot(key);
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          if (tbl_count > 0) tbl_count--;
          ans.idx = IDX_OUT_W'(hit);
        end else begin
          ans.status = ST_NOT_FOUND;
        end
      end
      CMD_LOOKUP: begin
        hit = find_slot(key);
        if (hit >= 0) begin
          ans.idx  = IDX_OUT_W'(hit);
          ans.fkey = slot_key[hit];
          ans.fval = slot_val[hit];
        end else begin
          ans.status = ST_NOT_FOUND;
        end
      end
      CMD_REWIND: begin
        iter_pos = 0;
      end
      CMD_NEXT: begin
        got = 1'b0;
        while (iter_pos < DEPTH && !got) begin
          pos = iter_pos;
          iter_pos++;
          if (slot_used[pos]) begin
            got      = 1'b1;
            ans.idx  = IDX_OUT_W'(pos);
            ans.fkey = slot_key[pos];
            ans.fval = slot_val[pos];
          end
        end
        if (!got) begin
          iter_pos   = DEPTH;
          ans.status = ST_ITER_END;
        end
      end
      default: begin
        // unused codes: no effect
      end
    endcase
    ans.count = CNT_OUT_W'(tbl_count);
    ans.mark  = CNT_OUT_W'(tbl_mark);
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // receiver side: new stall decision every falling edge
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  // one command beat; valid is left high so the next beat can follow directly
  task automatic send_command(input logic [CMD_W-1:0] cmd,
                              input logic [DATA_W-1:0] key,
                              input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    key_i      <= key;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    pending_answers.push_back(apply_command(cmd, key, value));
  endtask

  // drop valid and hold off until the block has answered everything
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // sampled before the edge updates anything, so no race with the block
  always @(posedge clk_i) begin
    table_answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        error_count++;
        $display("%0t ns: result beat with nothing expected: status %h slot %h",
                 $time, status_o, slot_index_o);
      end else begin
        want = pending_answers.pop_front();
        compare_field("status",      DATA_W'(want.status), DATA_W'(status_o));
        compare_field("slot_index",  DATA_W'(want.idx),    DATA_W'(slot_index_o));
        compare_field("found_key",   want.fkey,            found_key_o);
        compare_field("found_value", want.fval,            found_value_o);
        compare_field("entry_count", DATA_W'(want.count),  DATA_W'(entry_count_o));
        compare_field("high_water",  DATA_W'(want.mark),   DATA_W'(high_water_o));
      end
    end
  end

  // fires only when neither channel moves a beat for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // empty-table misses, unused codes, extreme keys/values, overwrite,
  // hole reuse and a full iterator walk that runs off the end
  task automatic test_directed();
    send_command(CMD_LOOKUP, WORD_MAX,  WORD_ZERO);   // miss on empty table
    send_command(CMD_REMOVE, WORD_ZERO, WORD_ZERO);   // miss on empty table
    send_command(CMD_NEXT,   WORD_ZERO, WORD_ZERO);   // iterator runs out
    send_command(CMD_NEXT,   WORD_ZERO, WORD_ZERO);   // stays at the end
    send_command(CMD_REWIND, WORD_ONES, WORD_ONES);
    send_command(CMD_RSVD5,  WORD_ONES, WORD_ONES);
    send_command(CMD_RSVD6,  WORD_MIN,  WORD_MAX);
    send_command(CMD_RSVD7,  WORD_ALT_A, WORD_ALT_B);
    send_command(CMD_INSERT, WORD_MIN,  WORD_MAX);    // slot 0
    send_command(CMD_INSERT, WORD_MAX,  WORD_MIN);    // slot 1
    send_command(CMD_INSERT, WORD_ZERO, WORD_ZERO);   // slot 2
    send_command(CMD_INSERT, WORD_ONES, WORD_ONES);   // slot 3
    send_command(CMD_INSERT, WORD_MAX,  WORD_ALT_A);  // overwrite slot 1
    send_command(CMD_LOOKUP, WORD_MAX,  WORD_ZERO);
    send_command(CMD_REMOVE, WORD_ZERO, WORD_ONES);   // hole at slot 2
    send_command(CMD_LOOKUP, WORD_ZERO, WORD_ZERO);   // gone
    send_command(CMD_REMOVE, WORD_ZERO, WORD_ZERO);   // already gone
    send_command(CMD_INSERT, WORD_ALT_A, WORD_ALT_B); // fills the hole
    send_command(CMD_INSERT, WORD_ALT_B, WORD_ALT_A); // appends at slot 4
    send_command(CMD_REWIND, WORD_ZERO, WORD_ZERO);
    repeat (6) send_command(CMD_NEXT, WORD_ZERO, WORD_ZERO);
  endtask

  // fill every slot, hit the full case, overwrite and reuse while full,
  // then empty the table again (mark stays at the top)
  task automatic test_fill_table();
    int victim;
    while (tbl_count < DEPTH) send_command(CMD_INSERT, fresh_key(), $urandom);
    send_command(CMD_INSERT, fresh_key(), $urandom);              // full
    send_command(CMD_LOOKUP, slot_key[DEPTH-1], $urandom);        // longest hit
    send_command(CMD_INSERT, slot_key[DEPTH-1], $urandom);        // overwrite while full
    send_command(CMD_LOOKUP, fresh_key(), $urandom);              // longest miss
    send_command(CMD_INSERT, fresh_key(), $urandom);              // still full
    victim = $urandom_range(DEPTH - 2, 1);
    send_command(CMD_REMOVE, slot_key[victim], $urandom);
    send_command(CMD_INSERT, fresh_key(), $urandom);              // lands in the hole
    send_command(CMD_REWIND, $urandom, $urandom);
    repeat (4) send_command(CMD_NEXT, $urandom, $urandom);
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_used[i]) send_command(CMD_REMOVE, slot_key[i], $urandom);
    end
    send_command(CMD_NEXT, $urandom, $urandom);                   // empty: end
    send_command(CMD_REMOVE, fresh_key(), $urandom);              // miss on empty
  endtask

  // mostly pool keys so inserts, removes and lookups keep hitting;
  // a slice of fresh keys and unused codes as noise
  task automatic test_random(input int items, input int pool_size);
    int pick;
    key_pool.delete();
    key_pool.push_back(WORD_MIN);
    key_pool.push_back(WORD_MAX);
    key_pool.push_back(WORD_ZERO);
    key_pool.push_back(WORD_ONES);
    while (key_pool.size() < pool_size) key_pool.push_back($urandom);
    repeat (items) begin
      pick = $urandom_range(99);
      if (pick < 40)
        send_command(CMD_INSERT, key_pool[$urandom_range(pool_size - 1)], $urandom);
      else if (pick < 57)
        send_command(CMD_REMOVE, key_pool[$urandom_range(pool_size - 1)], $urandom);
      else if (pick < 76)
        send_command(CMD_LOOKUP, key_pool[$urandom_range(pool_size - 1)], $urandom);
      else if (pick < 81)
        send_command(($urandom_range(1) != 0) ? CMD_LOOKUP : CMD_REMOVE, $urandom,
                     $urandom);
      else if (pick < 85)
        send_command(CMD_REWIND, $urandom, $urandom);
      else if (pick < 97)
        send_command(CMD_NEXT, $urandom, $urandom);
      else
        send_command(CMD_W'($urandom_range(CMD_RSVD7, CMD_RSVD5)), $urandom, $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // slow receiver
    set_idling(36, 82);
    test_directed();
    test_fill_table();
    test_random(60, 12);
    wait_for_results();

    // slow sender, bigger pool
    set_idling(82, 36);
    test_random(100, 40);
    wait_for_results();

    // full rate, pool larger than the table so it fills up at times
    set_idling(0, 0);
    test_random(130, 72);
    wait_for_results();

    // catch any stray beat after the last answer
    repeat (DEPTH + 8) @(posedge clk_i);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* key_value_slot_table_unit.f */
rtl/core/kvst_pkg.sv
rtl/core/kvst_ram.sv
rtl/core/kvst_ctrl.sv
rtl/core/kvst_dpath.sv
rtl/core/key_value_slot_table_unit.sv
sim/testbench.sv
